### sv/positional_ordered_list_defines.svh
// Assertion macros used by the top RTL file of the ordered list.
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// Checked outside reset.
`define POL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ordered list assertion failed");

// Checked at every edge, reset included.
`define POL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ordered list assertion failed");

`else

`define POL_ASSERT(label, clk, rst, prop)
`define POL_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### sv/pol_pkg.sv
package pol_pkg;

  // Number of slots in the list.
  localparam int CAPACITY = 16;

  // Field widths of the request and response words.
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int LEN_W = 5;

  // Count register width: it must hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Width used to compare positions, counts and slot indexes.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_ERASE  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_BAD  = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Command broadcast to every cell of the row. The insert and remove
  // flags are only set for requests that were accepted and are legal.
  typedef struct packed {
    logic                    insert;
    logic                    remove;
    logic                    erase;
    logic [CMP_W-1:0]        pos;
    logic [CMP_W-1:0]        count;
    logic signed [VAL_W-1:0] value;
  } pol_ctrl_t;

endpackage

### sv/pol_if.sv
interface pol_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic signed [pol_pkg::VAL_W-1:0] value;
  logic [pol_pkg::POS_W-1:0]       position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink (input valid, input action, input value, input position, output ready);
endinterface

interface pol_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [pol_pkg::LEN_W-1:0] length;

  modport source (output valid, output status, output length, input ready);
  modport sink (input valid, input status, input length, output ready);
endinterface

### sv/positional_ordered_list.sv
// Bounded ordered list of signed 32-bit values, front first.
// Requests arrive as words on the req channel (action, value, position)
// and each one produces exactly one response word on the rsp channel
// carrying a status and the number of entries held after the request.
// Insert places value at position (0 up to the count, the count appends),
// remove deletes the entry at position, erase deletes the first entry from
// the front that equals value. Illegal positions, a full list and the
// unused action code give status 1; an erase without a match gives 2.
// The list lives in a row of cells, one per slot; every cell takes its own
// word, its left or right neighbor's or the new value in the same cycle, and
// a match flag ripples down the row to find the first equal entry.
// The response word is registered in the cycle after acceptance; the
// block accepts one request per cycle unless stalled, bounded by the cell
// update together with that match ripple. The response sits in an output
// register; a new request is taken whenever that register is empty or being
// drained, so a stalled receiver stalls the request side after one word.
// Reset empties the list and drops any pending response; slot contents
// are not cleared, since only slots below the count are ever read.
module positional_ordered_list (
  input  logic     clk,
  input  logic     rst,
  pol_req_if.sink  req,
  pol_rsp_if.source rsp
);
  import pol_pkg::*;

`include "positional_ordered_list_defines.svh"

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  status_t                 status_next;
  logic                    accept;
  logic [CMP_W-1:0]        pos_x;
  logic [CMP_W-1:0]        cnt_x;
  logic                    ins_ok;
  logic                    rem_ok;
  logic                    found;
  pol_ctrl_t               ctrl;
  logic signed [VAL_W-1:0] slot [CAPACITY];
  logic                    hit [CAPACITY+1];

  // The response register frees up as soon as the receiver takes it.
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign pos_x  = CMP_W'(req.position);
  assign cnt_x  = CMP_W'(count);
  assign ins_ok = (pos_x <= cnt_x) && (count < CNT_W'(CAPACITY));
  assign rem_ok = pos_x < cnt_x;

  // Cells only move on accepted, legal requests. A failed erase moves
  // nothing because no cell ever raises the match flag.
  always_comb begin
    ctrl.insert = accept && (req.action == ACT_INSERT) && ins_ok;
    ctrl.remove = accept && (req.action == ACT_REMOVE) && rem_ok;
    ctrl.erase  = accept && (req.action == ACT_ERASE);
    ctrl.pos    = pos_x;
    ctrl.count  = cnt_x;
    ctrl.value  = req.value;
  end

  assign hit[0] = 1'b0;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_d;
      logic signed [VAL_W-1:0] right_d;

      if (i == 0) begin : g_first
        assign left_d = req.value;
      end else begin : g_left
        assign left_d = slot[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign right_d = slot[i];
      end else begin : g_right
        assign right_d = slot[i+1];
      end

      pol_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .index      (CMP_W'(i)),
        .left_data  (left_d),
        .right_data (right_d),
        .hit_in     (hit[i]),
        .data       (slot[i]),
        .hit_out    (hit[i+1])
      );
    end
  endgenerate

  assign found = hit[CAPACITY];

  always_comb begin
    count_next  = count;
    status_next = ST_BAD;
    case (req.action)
      ACT_INSERT: begin
        if (ins_ok) begin
          count_next  = count + CNT_W'(1);
          status_next = ST_DONE;
        end
      end
      ACT_REMOVE: begin
        if (rem_ok) begin
          count_next  = count - CNT_W'(1);
          status_next = ST_DONE;
        end
      end
      ACT_ERASE: begin
        if (found) begin
          count_next  = count - CNT_W'(1);
          status_next = ST_DONE;
        end else begin
          status_next = ST_MISS;
        end
      end
      default: begin
        status_next = ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Response payload needs no reset; it is qualified by rsp.valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status <= status_next;
      rsp.length <= LEN_W'(CMP_W'(count_next));
    end
  end

  `POL_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY))
  `POL_ASSERT(a_rsp_follows, clk, rst, accept |=> rsp.valid)
  `POL_ASSERT(a_insert_grows, clk, rst,
    (accept && (req.action == ACT_INSERT) && (status_next == ST_DONE))
      |=> (count == $past(count) + CNT_W'(1)))
  `POL_ASSERT(a_miss_only_erase, clk, rst,
    (accept && (status_next == ST_MISS)) |-> (req.action == ACT_ERASE))
  `POL_ASSERT_ALWAYS(a_reset_empty, clk,
    $past(rst) |-> ((count == '0) && !rsp.valid))

endmodule

### sv/pol_cell.sv
module pol_cell (
  input  logic                             clk,
  input  pol_pkg::pol_ctrl_t               ctrl,
  input  logic [pol_pkg::CMP_W-1:0]        index,
  input  logic signed [pol_pkg::VAL_W-1:0] left_data,
  input  logic signed [pol_pkg::VAL_W-1:0] right_data,
  input  logic                             hit_in,
  output logic signed [pol_pkg::VAL_W-1:0] data,
  output logic                             hit_out
);
  import pol_pkg::*;

  logic live;
  logic match;
  logic take_right;

  // A cell only matches while it holds a live entry of the list.
  assign live    = index < ctrl.count;
  assign match   = ctrl.erase && live && (data == ctrl.value);
  assign hit_out = hit_in | match;

  // Removal and erase close the gap: the removed or first matching cell and all
  // behind it pull the word of their right neighbor.
  assign take_right = (ctrl.remove && (index >= ctrl.pos)) || (ctrl.erase && hit_out);

  always_ff @(posedge clk) begin
    if (ctrl.insert && (index > ctrl.pos)) begin
      data <= left_data;
    end else if (ctrl.insert && (index == ctrl.pos)) begin
      data <= ctrl.value;
    end else if (take_right) begin
      data <= right_data;
    end
  end

endmodule
